### sv/mrf_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU request framer. No dependencies.
`default_nettype none

package mrf_pkg;

  // Input opcode field
  typedef enum logic [1:0] {
    OP_READ_HOLDING  = 2'd0,
    OP_WRITE_SINGLE  = 2'd1,
    OP_WRITE_MULTI   = 2'd2,
    OP_DATA          = 2'd3
  } opcode_t;

  // Modbus function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Control from the byte sequencer to the CRC accumulator
  typedef struct packed {
    logic       load;       // fold data into the running CRC
    logic       from_init;  // start from the initial value (first byte of a frame)
    logic       clear;      // frame closed: return to the initial value
    logic [7:0] data;
  } crc_ctl_t;

  // Fold one byte into the reflected CRC, one polynomial step per bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/modbus_request_framer.sv
// Modbus RTU request framer: byte sequencer, frame state and output register.
// Depends on mrf_pkg and mrf_crc16.
//
// Usage
//   Input channel (in_valid / in_stall) takes one word per item: a header
//   (read holding, write single, write multiple) or a payload data byte.
//   Output channel (out_valid / out_stall) gives one word per frame byte in
//   wire order: tx_byte, frame_end on the CRC high byte, run_last on the last
//   byte that an input word produces.
//   An accepted word sits in an item register; a sequencer index walks its
//   bytes, one per cycle unless the output stalls, into the output register.
//   Throughput is set by the output port, one byte per cycle while out_stall
//   is low: a read or write single header produces 8 bytes, a write multiple
//   header 7 (9 when its byte count is zero), a data byte 1 (3 when it is the
//   last of the payload and the CRC follows), a stray data byte none. The next
//   word is taken in the cycle the current word's last byte enters the output
//   register.
//   While out_stall is high and out_valid is set, the output word holds and
//   the sequencer waits; in_stall rises once the item register is occupied.
//   Reset (synchronous) empties both registers, closes any open frame and
//   sets the CRC to 0xFFFF.
`default_nettype none

module modbus_request_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  slave_address,
  input  wire logic [15:0] start_address,
  input  wire logic [15:0] quantity_or_value,
  input  wire logic [7:0]  byte_count,
  input  wire logic [7:0]  data_byte,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       tx_byte,
  output logic             frame_end,
  output logic             run_last
);

  // Item register
  logic             item_valid;
  logic [1:0]       item_op;
  logic [7:0]       item_slave;
  logic [15:0]      item_addr;
  logic [15:0]      item_qv;
  logic [7:0]       item_cnt;
  logic [7:0]       item_data;
  logic [3:0]       idx;

  // Frame state
  logic             payload_open;
  logic [7:0]       bytes_remaining;
  logic             crc_tail;

  logic [15:0]      crc;
  mrf_pkg::crc_ctl_t crc_ctl;

  mrf_pkg::opcode_t op;
  logic             is_header;
  logic [3:0]       data_len;
  logic             crc_follow;
  logic             drop;
  logic             is_crc_lo;
  logic             is_crc_hi;
  logic             last;
  logic             advance;
  logic             emit;
  logic [7:0]       fc;
  logic [7:0]       byte_sel;

  // Decode the held word and the current sequencer position
  always_comb begin
    op        = mrf_pkg::opcode_t'(item_op);
    is_header = (op != mrf_pkg::OP_DATA);
    if (is_header) begin
      data_len   = (op == mrf_pkg::OP_WRITE_MULTI) ? 4'd7 : 4'd6;
      crc_follow = (op != mrf_pkg::OP_WRITE_MULTI) || (item_cnt == 8'd0);
    end else begin
      data_len   = 4'd1;
      crc_follow = (idx == 4'd0) ? (bytes_remaining == 8'd1) : crc_tail;
    end
    drop      = !is_header && !payload_open && (idx == 4'd0);
    is_crc_lo = crc_follow && (idx == data_len);
    is_crc_hi = crc_follow && (idx == data_len + 4'd1);
    last      = drop || (crc_follow ? is_crc_hi : (idx == data_len - 4'd1));
    advance   = item_valid && (!out_valid || !out_stall);
    emit      = advance && !drop;
    in_stall  = item_valid && !(advance && last);
  end

  // Function code of the header
  always_comb begin
    unique case (op)
      mrf_pkg::OP_READ_HOLDING: fc = mrf_pkg::FC_READ_HOLDING;
      mrf_pkg::OP_WRITE_SINGLE: fc = mrf_pkg::FC_WRITE_SINGLE;
      default:                  fc = mrf_pkg::FC_WRITE_MULTI;
    endcase
  end

  // Select the byte at the sequencer position
  always_comb begin
    byte_sel = 8'h00;
    if (is_crc_lo) begin
      byte_sel = crc[7:0];
    end else if (is_crc_hi) begin
      byte_sel = crc[15:8];
    end else if (!is_header) begin
      byte_sel = item_data;
    end else begin
      unique case (idx)
        4'd0:    byte_sel = item_slave;
        4'd1:    byte_sel = fc;
        4'd2:    byte_sel = item_addr[15:8];
        4'd3:    byte_sel = item_addr[7:0];
        4'd4:    byte_sel = item_qv[15:8];
        4'd5:    byte_sel = item_qv[7:0];
        4'd6:    byte_sel = item_cnt;
        default: byte_sel = 8'h00;
      endcase
    end
  end

  // Drive the CRC accumulator
  always_comb begin
    crc_ctl.load      = emit && !is_crc_lo && !is_crc_hi;
    crc_ctl.from_init = is_header && (idx == 4'd0);
    crc_ctl.clear     = emit && is_crc_hi;
    crc_ctl.data      = byte_sel;
  end

  mrf_crc16 u_crc (
    .clk (clk),
    .rst (rst),
    .ctl (crc_ctl),
    .crc (crc)
  );

  // Capture words, advance the sequencer, update frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid      <= 1'b0;
      idx             <= 4'd0;
      payload_open    <= 1'b0;
      bytes_remaining <= 8'd0;
      crc_tail        <= 1'b0;
    end else begin
      if (advance) begin
        idx <= last ? 4'd0 : idx + 4'd1;
      end
      if (emit && (idx == 4'd0)) begin
        if (is_header) begin
          payload_open    <= (op == mrf_pkg::OP_WRITE_MULTI) && (item_cnt != 8'd0);
          bytes_remaining <= (op == mrf_pkg::OP_WRITE_MULTI) ? item_cnt : 8'd0;
        end else begin
          bytes_remaining <= bytes_remaining - 8'd1;
          crc_tail        <= (bytes_remaining == 8'd1);
          if (bytes_remaining == 8'd1) begin
            payload_open <= 1'b0;
          end
        end
      end
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (advance && last) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Load the item payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_op    <= opcode;
      item_slave <= slave_address;
      item_addr  <= start_address;
      item_qv    <= quantity_or_value;
      item_cnt   <= byte_count;
      item_data  <= data_byte;
    end
  end

  // Output register: fill on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_byte   <= byte_sel;
      frame_end <= is_crc_hi;
      run_last  <= last;
    end
  end

  // Checks on frame state and sequencing
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("frame_end without run_last");

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    payload_open |-> (bytes_remaining != 8'd0))
    else $error("open frame with no bytes remaining");

  a_closed_no_bytes: assert property (@(posedge clk) disable iff (rst)
    !payload_open |-> (bytes_remaining == 8'd0))
    else $error("closed frame with bytes remaining");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (idx <= 4'd8))
    else $error("sequencer index out of range");

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    emit && is_crc_hi |=> (crc == mrf_pkg::CRC_INIT))
    else $error("CRC not restarted after frame end");

endmodule

`default_nettype wire

### sv/mrf_crc16.sv
// Running CRC-16/MODBUS accumulator for the request framer.
// Depends on mrf_pkg (crc_ctl_t, crc_feed, CRC_INIT).
`default_nettype none

module mrf_crc16 (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mrf_pkg::crc_ctl_t ctl,
  output logic [15:0]           crc
);

  logic [15:0] base;
  logic [15:0] crc_next;

  // Pick the start value and fold in the byte, or restart on clear
  always_comb begin
    base     = ctl.from_init ? mrf_pkg::CRC_INIT : crc;
    crc_next = crc;
    if (ctl.clear) begin
      crc_next = mrf_pkg::CRC_INIT;
    end else if (ctl.load) begin
      crc_next = mrf_pkg::crc_feed(base, ctl.data);
    end
  end

  // Hold the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= mrf_pkg::CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for modbus_request_framer: random and directed request words,
// a built-in frame/CRC-16 predictor and a byte-by-byte checker.
// Depends on mrf_pkg and the framer RTL.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned WORD_TARGET = 320;
  localparam int unsigned CHOKE_AT    = 200;
  localparam int unsigned CHOKE_LEN   = 300;
  localparam int unsigned TAIL_CYCLES = 30;

  // One request word as offered on the input channel
  typedef struct {
    mrf_pkg::opcode_t op;
    logic [7:0]       slave;
    logic [15:0]      addr;
    logic [15:0]      qv;
    logic [7:0]       cnt;
    logic [7:0]       dat;
    int unsigned      gap;
    bit               pause;
  } req_word_t;

  // One byte of a frame as seen on the output channel
  typedef struct {
    logic [7:0] tx;
    logic       fend;
    logic       rlast;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = mrf_pkg::OP_READ_HOLDING;
  logic [7:0]  slave_address = 8'h00;
  logic [15:0] start_address = 16'h0000;
  logic [15:0] quantity_or_value = 16'h0000;
  logic [7:0]  byte_count = 8'h00;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic        run_last;

  req_word_t   feed[$];
  wire_byte_t  frame_bytes[$];

  // Predictor state
  logic [15:0] frame_crc = mrf_pkg::CRC_INIT;
  logic [7:0]  payload_left = 8'h00;
  logic        frame_open = 1'b0;

  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned words_total = 0;
  int unsigned words_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned choke_left = 0;
  int unsigned rx_mode = 0;
  bit          send_burst = 1'b0;
  bit          pause_next = 1'b0;

  modbus_request_framer uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .slave_address     (slave_address),
    .start_address     (start_address),
    .quantity_or_value (quantity_or_value),
    .byte_count        (byte_count),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .tx_byte           (tx_byte),
    .frame_end         (frame_end),
    .run_last          (run_last)
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Reflected CRC-16, bit-serial form: feedback is crc LSB xor data bit
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ mrf_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void put_frame_byte(input logic [7:0] b);
    wire_byte_t e;
    frame_crc = crc16_fold(frame_crc, b);
    e.tx = b;
    e.fend = 1'b0;
    e.rlast = 1'b0;
    frame_bytes.push_back(e);
  endfunction

  // Close the frame: CRC low byte, then high byte with frame_end
  function automatic void put_frame_crc();
    wire_byte_t e;
    e.tx = frame_crc[7:0];
    e.fend = 1'b0;
    e.rlast = 1'b0;
    frame_bytes.push_back(e);
    e.tx = frame_crc[15:8];
    e.fend = 1'b1;
    frame_bytes.push_back(e);
    frame_crc = mrf_pkg::CRC_INIT;
    frame_open = 1'b0;
    payload_left = 8'h00;
  endfunction

  // Work out the wire bytes that one accepted word produces
  function automatic void predict_frame_bytes(input req_word_t w);
    int unsigned first;
    logic [7:0] fc;
    first = frame_bytes.size();
    if (w.op == mrf_pkg::OP_DATA) begin
      if (frame_open) begin
        put_frame_byte(w.dat);
        payload_left = payload_left - 8'd1;
        if (payload_left == 8'd0) put_frame_crc();
      end
    end else begin
      case (w.op)
        mrf_pkg::OP_READ_HOLDING: fc = mrf_pkg::FC_READ_HOLDING;
        mrf_pkg::OP_WRITE_SINGLE: fc = mrf_pkg::FC_WRITE_SINGLE;
        default:                  fc = mrf_pkg::FC_WRITE_MULTI;
      endcase
      // a header always starts over, abandoning any open frame
      frame_crc = mrf_pkg::CRC_INIT;
      frame_open = 1'b0;
      payload_left = 8'h00;
      put_frame_byte(w.slave);
      put_frame_byte(fc);
      put_frame_byte(w.addr[15:8]);
      put_frame_byte(w.addr[7:0]);
      put_frame_byte(w.qv[15:8]);
      put_frame_byte(w.qv[7:0]);
      if (w.op == mrf_pkg::OP_WRITE_MULTI) begin
        put_frame_byte(w.cnt);
        if (w.cnt == 8'd0) begin
          put_frame_crc();
        end else begin
          frame_open = 1'b1;
          payload_left = w.cnt;
        end
      end else begin
        put_frame_crc();
      end
    end
    if (frame_bytes.size() > first) frame_bytes[frame_bytes.size() - 1].rlast = 1'b1;
  endfunction

  // Queue one word for the driver; the gap comes from the current pacing
  task automatic queue_word(input mrf_pkg::opcode_t op, input logic [7:0] sa,
                            input logic [15:0] ra, input logic [15:0] qv,
                            input logic [7:0] bc, input logic [7:0] db);
    req_word_t w;
    w.op = op;
    w.slave = sa;
    w.addr = ra;
    w.qv = qv;
    w.cnt = bc;
    w.dat = db;
    w.gap = send_burst ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 13) : 0);
    w.pause = pause_next;
    pause_next = 1'b0;
    feed.push_back(w);
  endtask

  task automatic queue_rand(input mrf_pkg::opcode_t op, input logic [7:0] bc);
    queue_word(op, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), bc, 8'($urandom_range(0, 255)));
  endtask

  // Stimulus: directed words first, then random frames with noise
  initial begin : stimulus
    int unsigned counted;
    int unsigned pick;
    int unsigned cnt;
    int unsigned cut;
    int unsigned next_pause;
    bit big_done;
    counted = 0;
    next_pause = 60;
    big_done = 1'b0;

    queue_word(mrf_pkg::OP_READ_HOLDING, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_word(mrf_pkg::OP_READ_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    queue_rand(mrf_pkg::OP_WRITE_SINGLE, 8'($urandom_range(0, 255)));
    queue_word(mrf_pkg::OP_WRITE_MULTI, 8'hA5, 16'h5A5A, 16'h0000, 8'h00, 8'h00);
    // data with no frame open is dropped
    queue_word(mrf_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'hFF);
    queue_word(mrf_pkg::OP_WRITE_MULTI, 8'h11, 16'h0001, 16'h0001, 8'h02, 8'h00);
    queue_word(mrf_pkg::OP_DATA, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00);
    queue_word(mrf_pkg::OP_DATA, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'hFF);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    // a write single header abandons an open payload
    queue_rand(mrf_pkg::OP_WRITE_MULTI, 8'h03);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    queue_rand(mrf_pkg::OP_WRITE_SINGLE, 8'h00);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    queue_rand(mrf_pkg::OP_WRITE_MULTI, 8'h01);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    // a write multiple header abandons an open payload
    queue_rand(mrf_pkg::OP_WRITE_MULTI, 8'h03);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    queue_rand(mrf_pkg::OP_WRITE_MULTI, 8'h01);
    queue_rand(mrf_pkg::OP_DATA, 8'h00);
    pause_next = 1'b1;

    while (counted < WORD_TARGET) begin
      send_burst = ($urandom_range(0, 3) == 0);
      if (counted >= next_pause) begin
        pause_next = 1'b1;
        next_pause = next_pause + 60;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_rand(mrf_pkg::opcode_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        counted++;
      end else if (pick < 85) begin
        pick = $urandom_range(0, 99);
        cnt = (pick < 5) ? 0 : (pick < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        if (!big_done && counted > 150) begin
          cnt = 255;
          big_done = 1'b1;
        end
        // now and then cut the payload short; the next header abandons it
        cut = (cnt > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, cnt - 1) : cnt;
        queue_rand(mrf_pkg::OP_WRITE_MULTI, 8'(cnt));
        counted++;
        for (int i = 0; i < cut; i++) begin
          queue_rand(mrf_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        end
        counted += cut;
      end else begin
        repeat ($urandom_range(1, 2)) begin
          queue_rand(mrf_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        end
      end
    end
    words_total = feed.size();
  end

  // Input driver: hold a stalled word, otherwise idle or offer the next one
  always @(negedge clk) begin : drive
    req_word_t w;
    if (!rst && !(in_valid && !in_taken)) begin
      if (feed.size() > 0 && idle_cnt < feed[0].gap) begin
        idle_cnt <= idle_cnt + 1;
        in_valid <= 1'b0;
      end else if (feed.size() > 0 && (!feed[0].pause || frame_bytes.size() == 0)) begin
        w = feed.pop_front();
        opcode <= w.op;
        slave_address <= w.slave;
        start_address <= w.addr;
        quantity_or_value <= w.qv;
        byte_count <= w.cnt;
        data_byte <= w.dat;
        in_valid <= 1'b1;
        idle_cnt <= 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls per byte, one long hold-off
  always @(negedge clk) begin : receive
    int unsigned n;
    if (!rst) begin
      if (out_taken && bytes_seen % 48 == 0) rx_mode = $urandom_range(0, 2);
      if (out_taken && bytes_seen == CHOKE_AT) begin
        choke_left <= CHOKE_LEN - 1;
        out_stall <= 1'b1;
      end else if (choke_left > 0) begin
        choke_left <= choke_left - 1;
        out_stall <= 1'b1;
      end else if (out_taken) begin
        case (rx_mode)
          0:       n = 0;
          1:       n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
          default: n = $urandom_range(0, 13);
        endcase
        out_stall <= (n > 0);
        stall_left <= (n > 0) ? n - 1 : 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted words, check accepted bytes in order
  always @(posedge clk) begin : watch
    req_word_t w;
    wire_byte_t want;
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        w.op = mrf_pkg::opcode_t'(opcode);
        w.slave = slave_address;
        w.addr = start_address;
        w.qv = quantity_or_value;
        w.cnt = byte_count;
        w.dat = data_byte;
        predict_frame_bytes(w);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        bytes_seen++;
        if (frame_bytes.size() == 0) begin
          $error("unexpected word: tx_byte=%02h frame_end=%0b run_last=%0b",
                 tx_byte, frame_end, run_last);
          errors++;
        end else begin
          want = frame_bytes.pop_front();
          if (tx_byte !== want.tx) begin
            $error("tx_byte: expected %02h, got %02h", want.tx, tx_byte);
            errors++;
          end
          if (frame_end !== want.fend) begin
            $error("frame_end: expected %0b, got %0b", want.fend, frame_end);
            errors++;
          end
          if (run_last !== want.rlast) begin
            $error("run_last: expected %0b, got %0b", want.rlast, run_last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Drain, let the block settle, then report
  initial begin : finish_run
    wait (rst == 1'b0);
    while (!(words_taken == words_total && frame_bytes.size() == 0)) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
